// ===== rtl/iasmd_pkg.sv =====
`default_nettype none
package iasmd_pkg;

  // Operand geometry
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CNT_W  = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 2'd3;

  // Microcode addresses
  localparam int unsigned UPC_W = 3;
  localparam logic [UPC_W-1:0] UPC_FETCH   = 3'd0;
  localparam logic [UPC_W-1:0] UPC_ADD     = 3'd1;
  localparam logic [UPC_W-1:0] UPC_SUB     = 3'd2;
  localparam logic [UPC_W-1:0] UPC_MUL     = 3'd3;
  localparam logic [UPC_W-1:0] UPC_EMIT    = 3'd4;
  localparam logic [UPC_W-1:0] UPC_DIVPREP = 3'd5;
  localparam logic [UPC_W-1:0] UPC_DIV     = 3'd6;
  localparam logic [UPC_W-1:0] UPC_DIVFIX  = 3'd7;

  // Datapath micro-operations
  typedef enum logic [2:0] {
    U_NOP,
    U_LOAD,
    U_ADD,
    U_SUB,
    U_MUL,
    U_ABS,
    U_DIV,
    U_FIX
  } uop_t;

  // Sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_LOOP,
    C_ZERO,
    C_WAIT_OUT
  } cond_t;

  typedef struct packed {
    uop_t             uop;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  // Control into the datapath
  typedef struct packed {
    uop_t uop;
    logic fire;
  } dp_ctrl_t;

  // Flags back to the sequencer
  typedef struct packed {
    logic cnt_nz;
    logic b_zero;
  } dp_stat_t;

  // Control store
  function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctrl_word_t cw;
    cw = '{uop: U_NOP, cond: C_JUMP, target: UPC_FETCH};
    case (upc)
      UPC_FETCH:   cw = '{uop: U_LOAD, cond: C_WAIT_IN,  target: UPC_FETCH};
      UPC_ADD:     cw = '{uop: U_ADD,  cond: C_JUMP,     target: UPC_EMIT};
      UPC_SUB:     cw = '{uop: U_SUB,  cond: C_JUMP,     target: UPC_EMIT};
      UPC_MUL:     cw = '{uop: U_MUL,  cond: C_LOOP,     target: UPC_MUL};
      UPC_EMIT:    cw = '{uop: U_NOP,  cond: C_WAIT_OUT, target: UPC_FETCH};
      UPC_DIVPREP: cw = '{uop: U_ABS,  cond: C_ZERO,     target: UPC_EMIT};
      UPC_DIV:     cw = '{uop: U_DIV,  cond: C_LOOP,     target: UPC_DIV};
      UPC_DIVFIX:  cw = '{uop: U_FIX,  cond: C_JUMP,     target: UPC_EMIT};
      default:     cw = '{uop: U_NOP,  cond: C_JUMP,     target: UPC_FETCH};
    endcase
    return cw;
  endfunction

  // Entry point of each operation's routine
  function automatic logic [UPC_W-1:0] dispatch(input logic [KIND_W-1:0] kind);
    logic [UPC_W-1:0] upc;
    upc = UPC_FETCH;
    unique case (kind)
      KIND_ADD: upc = UPC_ADD;
      KIND_SUB: upc = UPC_SUB;
      KIND_MUL: upc = UPC_MUL;
      KIND_DIV: upc = UPC_DIVPREP;
      default:  upc = UPC_FETCH;
    endcase
    return upc;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/iasmd_if.sv =====
`default_nettype none
// Operation request channel
interface iasmd_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [iasmd_pkg::KIND_W-1:0]     kind;
  logic signed [iasmd_pkg::WORD_W-1:0]     operand_a;
  logic signed [iasmd_pkg::WORD_W-1:0]     operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

// Result channel
interface iasmd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [iasmd_pkg::WORD_W-1:0]     result;
  logic                                    status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/iasmd_datapath.sv =====
`default_nettype none
module iasmd_datapath (
  input  wire                             clk,
  input  wire iasmd_pkg::dp_ctrl_t        ctrl,
  input  wire [iasmd_pkg::WORD_W-1:0]     in_a,
  input  wire [iasmd_pkg::WORD_W-1:0]     in_b,
  output iasmd_pkg::dp_stat_t             stat,
  output logic [iasmd_pkg::WORD_W-1:0]    acc,
  output logic                            status
);

  localparam int unsigned W = iasmd_pkg::WORD_W;

  logic [W-1:0]                    a_r, a_nxt;     // multiplicand / dividend, then quotient
  logic [W-1:0]                    b_r, b_nxt;     // multiplier / divisor
  logic [W-1:0]                    acc_r, acc_nxt;
  logic [W-1:0]                    rem_r, rem_nxt;
  logic [iasmd_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            neg_r, neg_nxt;
  logic                            status_r, status_nxt;

  logic [W-1:0]                    rem_sh;
  logic [W:0]                      diff;

  // Restoring divide trial subtract
  assign rem_sh = {rem_r[W-2:0], a_r[W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, b_r};

  always_comb begin
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    status_nxt = status_r;
    if (ctrl.fire) begin
      case (ctrl.uop)
        iasmd_pkg::U_LOAD: begin
          a_nxt      = in_a;
          b_nxt      = in_b;
          acc_nxt    = '0;
          rem_nxt    = '0;
          cnt_nxt    = iasmd_pkg::CNT_LAST;
          neg_nxt    = 1'b0;
          status_nxt = 1'b0;
        end
        iasmd_pkg::U_ADD: acc_nxt = a_r + b_r;
        iasmd_pkg::U_SUB: acc_nxt = a_r + ~b_r + W'(1);
        iasmd_pkg::U_MUL: begin
          if (b_r[0]) acc_nxt = acc_r + a_r;
          a_nxt   = {a_r[W-2:0], 1'b0};
          b_nxt   = {1'b0, b_r[W-1:1]};
          cnt_nxt = cnt_r - 1'b1;
        end
        iasmd_pkg::U_ABS: begin
          a_nxt      = a_r[W-1] ? (~a_r + W'(1)) : a_r;
          b_nxt      = b_r[W-1] ? (~b_r + W'(1)) : b_r;
          neg_nxt    = a_r[W-1] ^ b_r[W-1];
          status_nxt = (b_r == '0);
        end
        iasmd_pkg::U_DIV: begin
          // Quotient bits shift into a_r as dividend bits shift out
          if (!diff[W]) begin
            rem_nxt = diff[W-1:0];
            a_nxt   = {a_r[W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            a_nxt   = {a_r[W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r - 1'b1;
        end
        iasmd_pkg::U_FIX: acc_nxt = neg_r ? (~a_r + W'(1)) : a_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    status_r <= status_nxt;
  end

  assign stat.cnt_nz = (cnt_r != '0);
  assign stat.b_zero = (b_r == '0);
  assign acc         = acc_r;
  assign status      = status_r;

endmodule
`default_nettype wire

// ===== rtl/integer_add_sub_mul_div_alu.sv =====
// Sequence, input transfer to result valid: add/sub one step, multiply one
//   step per multiplier bit, divide sign prep, 32 shift-subtract steps and
//   sign fix, divide by zero the sign prep only; each then goes to the emit step.
// A new item is taken only once the last has passed the emit step; the sequencer
//   returns to fetch and takes the next item while the result register still waits.
// Reset (rst_n low, synchronous): microcode PC to fetch, result register empty.
`default_nettype none
module integer_add_sub_mul_div_alu (
  input  wire             clk,
  input  wire             rst_n,
  iasmd_in_if.sink        in_ch,
  iasmd_out_if.source     out_ch
);

  localparam int unsigned W = iasmd_pkg::WORD_W;

  logic [iasmd_pkg::UPC_W-1:0] upc_r, upc_nxt;
  iasmd_pkg::ctrl_word_t       cw;
  iasmd_pkg::dp_ctrl_t         dp_ctrl;
  iasmd_pkg::dp_stat_t         dp_stat;
  logic [W-1:0]                dp_acc;
  logic                        dp_status;

  logic                        in_xfer;
  logic                        out_free;
  logic                        out_valid_r;
  logic [W-1:0]                out_result_r;
  logic                        out_status_r;

  // Control word fetch
  assign cw       = iasmd_pkg::ucode_rom(upc_r);
  assign in_ch.ready = rst_n && (upc_r == iasmd_pkg::UPC_FETCH);
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Datapath step fires unless the control word waits for input; then it fires on the input transfer
  always_comb begin
    dp_ctrl.uop  = cw.uop;
    dp_ctrl.fire = (cw.cond == iasmd_pkg::C_WAIT_IN) ? in_xfer : 1'b1;
  end

  // Next microcode address
  always_comb begin
    upc_nxt = upc_r + 1'b1;
    unique case (cw.cond)
      iasmd_pkg::C_NEXT:     upc_nxt = upc_r + 1'b1;
      iasmd_pkg::C_JUMP:     upc_nxt = cw.target;
      iasmd_pkg::C_WAIT_IN:  upc_nxt = in_xfer ? iasmd_pkg::dispatch(in_ch.kind) : upc_r;
      iasmd_pkg::C_LOOP:     upc_nxt = dp_stat.cnt_nz ? cw.target : upc_r + 1'b1;
      iasmd_pkg::C_ZERO:     upc_nxt = dp_stat.b_zero ? cw.target : upc_r + 1'b1;
      iasmd_pkg::C_WAIT_OUT: upc_nxt = out_free ? cw.target : upc_r;
      default:               upc_nxt = iasmd_pkg::UPC_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= iasmd_pkg::UPC_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  iasmd_datapath u_dp (
    .clk    (clk),
    .ctrl   (dp_ctrl),
    .in_a   (in_ch.operand_a),
    .in_b   (in_ch.operand_b),
    .stat   (dp_stat),
    .acc    (dp_acc),
    .status (dp_status)
  );

  // Result register, loaded by the emit step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.cond == iasmd_pkg::C_WAIT_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.cond == iasmd_pkg::C_WAIT_OUT && out_free) begin
      out_result_r <= dp_acc;
      out_status_r <= dp_status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = signed'(out_result_r);
  assign out_ch.status = out_status_r;

  // Checks
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (upc_r == iasmd_pkg::UPC_ADD || upc_r == iasmd_pkg::UPC_SUB ||
                 upc_r == iasmd_pkg::UPC_MUL || upc_r == iasmd_pkg::UPC_DIVPREP))
    else $error("bad dispatch after input transfer");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == iasmd_pkg::UPC_EMIT && out_free) |=>
      (out_valid_r && upc_r == iasmd_pkg::UPC_FETCH))
    else $error("emit step did not load the result register");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_result_r == '0))
    else $error("divide-by-zero status with nonzero result");

  a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((upc_r == iasmd_pkg::UPC_MUL || upc_r == iasmd_pkg::UPC_DIV) && dp_stat.cnt_nz)
      |=> ($stable(upc_r)))
    else $error("iteration loop left early");

endmodule
`default_nettype wire
